// ===== src/sample_loop_playback_voice_assert.svh =====
// ----------------------------------------------------------------------------
// sample_loop_playback_voice_assert.svh
// assertion macros shared by the voice modules; clk and rst_n are implied
// ----------------------------------------------------------------------------
`ifndef SAMPLE_LOOP_PLAYBACK_VOICE_ASSERT_SVH
`define SAMPLE_LOOP_PLAYBACK_VOICE_ASSERT_SVH

// same-cycle implication
`define SLPV_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLPV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/slpv_pkg.sv =====
// ----------------------------------------------------------------------------
// slpv_pkg
// shared types and constants of the sample loop playback voice
// ----------------------------------------------------------------------------
package slpv_pkg;

  // field and register widths
  localparam int CFG_W     = 17;
  localparam int REG_IDX_W = 3;
  localparam int SAMPLE_W  = 16;
  localparam int SPEED_W   = 16;
  localparam int POS_W     = 17;
  localparam int ADDR_W    = 16;
  localparam int OP_W      = 2;
  // signed whole-step count taken from the stride accumulator
  localparam int STEP_W    = 18;

  localparam logic signed [SPEED_W-1:0] SPEED_RESET = 16'sd4096;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_PLAY_START  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PLAY_END    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LOOP_BEGIN  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LOOP_FINISH = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPEED       = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LOOP_ENABLE = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_CUT_ENABLE  = 3'd6;

  // request opcodes
  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 2'd0,
    OP_NOTE_ON  = 2'd1,
    OP_NOTE_OFF = 2'd2,
    OP_WRITE    = 2'd3
  } op_t;

  // controller to datapath commands
  typedef struct packed {
    logic mem_write;
    logic note_on;
    logic note_off;
    logic tick_start;
    logic out_load;
    logic step;
  } slpv_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic count_zero;
    logic count_last;
    logic out_free;
  } slpv_status_t;

endpackage

// ===== src/slpv_mem.sv =====
// ----------------------------------------------------------------------------
// slpv_mem
// sample store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module slpv_mem import slpv_pkg::*; #(
  parameter int SAMPLE_DEPTH = 65536,
  parameter int AW           = 16
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic signed [SAMPLE_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic signed [SAMPLE_W-1:0] rdata
);

  logic signed [SAMPLE_W-1:0] mem [SAMPLE_DEPTH];
  logic signed [SAMPLE_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/slpv_ctrl.sv =====
// ----------------------------------------------------------------------------
// slpv_ctrl
// request sequencer: decodes each request and walks a tick through the
// read, result and stepping phases
// ----------------------------------------------------------------------------
module slpv_ctrl import slpv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_op,
  input  slpv_status_t      status,
  output slpv_cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_STEP
  } state_t;

  state_t state_r;
  state_t state_nxt;
  op_t    op;

  assign op       = op_t'(in_op);
  assign in_ready = (state_r == ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (op)
            OP_WRITE: begin
              cmd.mem_write = 1'b1;
            end
            OP_NOTE_ON: begin
              cmd.note_on = 1'b1;
            end
            OP_NOTE_OFF: begin
              cmd.note_off = 1'b1;
            end
            OP_TICK: begin
              cmd.tick_start = 1'b1;
              state_nxt      = ST_READ;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = status.count_zero ? ST_IDLE : ST_STEP;
        end
      end
      ST_STEP: begin
        cmd.step = 1'b1;
        if (status.count_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `include "sample_loop_playback_voice_assert.svh"

  // stepping only runs with steps left to take
  `SLPV_ASSERT_IMPL(a_step_has_work, state_r == ST_STEP, !status.count_zero, "step with zero count")
  // an accepted tick always goes on to the memory read phase
  `SLPV_ASSERT_NEXT(a_tick_to_read, in_valid && in_ready && op == OP_TICK, state_r == ST_READ, "tick did not start read")

endmodule

// ===== src/slpv_dp.sv =====
// ----------------------------------------------------------------------------
// slpv_dp
// voice datapath: configuration registers, position and fraction state,
// sample store, step unit and result register
// ----------------------------------------------------------------------------
module slpv_dp import slpv_pkg::*; #(
  parameter int SAMPLE_DEPTH    = 65536,
  parameter int SPEED_FRAC_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [REG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_wdata,
  input  logic [ADDR_W-1:0]          in_write_addr,
  input  logic signed [SAMPLE_W-1:0] in_write_value,
  input  slpv_cmd_t                  cmd,
  output slpv_status_t               status,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  output logic [POS_W-1:0]           out_position
);

  localparam int IW     = $clog2(SAMPLE_DEPTH + 1);
  localparam int AW     = $clog2(SAMPLE_DEPTH);
  localparam int CW     = (IW > CFG_W) ? IW : CFG_W;
  localparam int ACC_W  = SPEED_FRAC_BITS + STEP_W;
  localparam logic [IW-1:0] DEPTH_IW = IW'(SAMPLE_DEPTH);

  // clamp a register point to the memory end
  function automatic logic [IW-1:0] clamp_pt(input logic [CFG_W-1:0] v);
    logic [CW-1:0] ve;
    ve = CW'(v);
    if (ve > CW'(SAMPLE_DEPTH)) begin
      return DEPTH_IW;
    end
    return IW'(ve);
  endfunction

  // configuration registers
  logic [CFG_W-1:0]          start_r;
  logic [CFG_W-1:0]          end_r;
  logic [CFG_W-1:0]          lbeg_r;
  logic [CFG_W-1:0]          lfin_r;
  logic signed [SPEED_W-1:0] speed_r;
  logic                      loop_en_r;
  logic                      cut_en_r;

  // voice state
  logic [IW-1:0]              idx_r;
  logic [SPEED_FRAC_BITS-1:0] frac_r;
  logic                       loop_act_r;
  logic                       running_r;
  logic                       reverse_r;
  logic signed [SPEED_W-1:0]  stride_r;
  logic [STEP_W-1:0]          count_r;
  logic                       dir_neg_r;

  // result register
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic [POS_W-1:0]           out_pos_r;

  logic [IW-1:0]              s_pt;
  logic [IW-1:0]              e_pt;
  logic [IW-1:0]              lb_pt;
  logic [IW-1:0]              lf_pt;
  logic signed [ACC_W-1:0]    acc;
  logic signed [STEP_W-1:0]   steps_s;
  logic [STEP_W-1:0]          steps_mag;
  logic [IW-1:0]              moved;
  logic [IW-1:0]              stepped;
  logic                       in_win;
  logic                       show;
  logic                       addr_ok;
  logic signed [SAMPLE_W-1:0] mem_rdata;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= '0;
      end_r     <= '0;
      lbeg_r    <= '0;
      lfin_r    <= '0;
      speed_r   <= SPEED_RESET;
      loop_en_r <= 1'b0;
      cut_en_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PLAY_START:  start_r   <= cfg_wdata;
        REG_PLAY_END:    end_r     <= cfg_wdata;
        REG_LOOP_BEGIN:  lbeg_r    <= cfg_wdata;
        REG_LOOP_FINISH: lfin_r    <= cfg_wdata;
        REG_SPEED:       speed_r   <= $signed(cfg_wdata[SPEED_W-1:0]);
        REG_LOOP_ENABLE: loop_en_r <= cfg_wdata[0];
        REG_CUT_ENABLE:  cut_en_r  <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign s_pt  = clamp_pt(start_r);
  assign e_pt  = clamp_pt(end_r);
  assign lb_pt = clamp_pt(lbeg_r);
  assign lf_pt = clamp_pt(lfin_r);

  // stride accumulator: whole steps and new fraction
  assign acc = $signed({{STEP_W{1'b0}}, frac_r}) + ACC_W'(stride_r);
  assign steps_s   = $signed(acc[ACC_W-1:SPEED_FRAC_BITS]);
  assign steps_mag = steps_s[STEP_W-1] ? STEP_W'(-steps_s) : STEP_W'(steps_s);

  // one index step with memory bounds and loop jump
  always_comb begin
    if (!dir_neg_r) begin
      moved = (idx_r < DEPTH_IW) ? idx_r + 1'b1 : idx_r;
    end else begin
      moved = (idx_r != '0) ? idx_r - 1'b1 : idx_r;
    end
    stepped = moved;
    if (loop_act_r) begin
      if (reverse_r) begin
        if (moved == lb_pt) begin
          stepped = lf_pt;
        end
      end else if (moved == lf_pt) begin
        stepped = lb_pt;
      end
    end
  end

  // play window test
  assign in_win = reverse_r ? (idx_r > s_pt && idx_r <= e_pt)
                            : (idx_r >= s_pt && idx_r < e_pt);
  assign show   = running_r && in_win && (idx_r < DEPTH_IW);

  // sample store
  assign addr_ok = ({{(32 - ADDR_W){1'b0}}, in_write_addr} < 32'(SAMPLE_DEPTH));

  slpv_mem #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH),
    .AW           (AW)
  ) u_mem (
    .clk   (clk),
    .we    (cmd.mem_write && addr_ok),
    .waddr (AW'(in_write_addr)),
    .wdata (in_write_value),
    .re    (cmd.tick_start),
    .raddr (idx_r[AW-1:0]),
    .rdata (mem_rdata)
  );

  // voice state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      frac_r      <= '0;
      loop_act_r  <= 1'b0;
      running_r   <= 1'b0;
      reverse_r   <= 1'b0;
      stride_r    <= '0;
      count_r     <= '0;
      dir_neg_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.note_on) begin
        stride_r   <= speed_r;
        reverse_r  <= speed_r[SPEED_W-1];
        idx_r      <= speed_r[SPEED_W-1] ? e_pt : s_pt;
        frac_r     <= '0;
        loop_act_r <= loop_en_r;
        running_r  <= 1'b1;
      end
      if (cmd.note_off) begin
        loop_act_r <= 1'b0;
        if (cut_en_r) begin
          running_r <= 1'b0;
          idx_r     <= e_pt;
          frac_r    <= '0;
          reverse_r <= 1'b0;
        end
      end
      if (cmd.tick_start) begin
        if (running_r) begin
          frac_r    <= acc[SPEED_FRAC_BITS-1:0];
          count_r   <= steps_mag;
          dir_neg_r <= steps_s[STEP_W-1];
        end else begin
          count_r <= '0;
        end
      end
      if (cmd.step) begin
        idx_r   <= stepped;
        count_r <= count_r - 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sample_r <= show ? mem_rdata : '0;
      out_pos_r    <= POS_W'(idx_r);
    end
  end

  assign status.count_zero = (count_r == '0);
  assign status.count_last = (count_r == STEP_W'(1));
  assign status.out_free   = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_position   = out_pos_r;

  `include "sample_loop_playback_voice_assert.svh"

  // position never runs past the memory end
  `SLPV_ASSERT_IMPL(a_idx_in_range, 1'b1, idx_r <= DEPTH_IW, "position beyond memory end")
  // a result is only loaded into a free or draining slot
  `SLPV_ASSERT_IMPL(a_load_free_slot, cmd.out_load, !out_valid_r || out_ready, "result overwritten")

endmodule

// ===== src/sample_loop_playback_voice.sv =====
// ----------------------------------------------------------------------------
// sample_loop_playback_voice
// single sampler voice with its own sample store and loop address generator
// ----------------------------------------------------------------------------
// Requests enter on the in_ channel (valid/ready): op selects tick, note on,
// note off or sample write. Only a tick produces a result on the out_
// channel: the sample at the current position (zero outside the play
// window or when stopped) and the position read. Registers are written on
// the cfg_ port at any edge with cfg_we high; the user must do so only
// while the voice is idle, as the block does not enforce it. Write, note
// on and note off complete on acceptance. A tick reads the sample store on
// acceptance, loads the result register (out_valid) once the output slot
// is free, then runs the position step unit for n steps, one index per
// cycle, where n is the whole step count of the stride accumulator, up to
// 8 at the default 12 fraction bits. A new request is taken once the step
// unit is done. If the receiver stalls, the finished result waits in the
// output register; a following tick holds in its load phase until the
// slot frees, taking no other request. Reset clears the voice to stopped
// at position zero with speed 4096; the sample store is not cleared.
// ----------------------------------------------------------------------------
module sample_loop_playback_voice import slpv_pkg::*; #(
  parameter int SAMPLE_DEPTH    = 65536,
  parameter int SPEED_FRAC_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration port
  input  logic                       cfg_we,
  input  logic [REG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_wdata,
  // request channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [OP_W-1:0]            in_op,
  input  logic [ADDR_W-1:0]          in_write_addr,
  input  logic signed [SAMPLE_W-1:0] in_write_value,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  output logic [POS_W-1:0]           out_position
);

  slpv_cmd_t    cmd;
  slpv_status_t status;

  // request sequencer
  slpv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_op),
    .status   (status),
    .cmd      (cmd)
  );

  // voice datapath
  slpv_dp #(
    .SAMPLE_DEPTH    (SAMPLE_DEPTH),
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_write_addr  (in_write_addr),
    .in_write_value (in_write_value),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_position   (out_position)
  );

endmodule
